>>> design/mrqs_pkg.sv
package mrqs_pkg;

    localparam int NUM_QUEUES_DEF   = 16;
    localparam int POOL_SIZE_DEF    = 256;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_TAKE_READY = 2'd1;
    localparam logic [1:0] REQ_TAKE_MSG = 2'd2;
    localparam logic [1:0] REQ_DONE = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  queue_id;
        logic [31:0] payload;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  queue_out;
        logic [31:0] payload_out;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } mrqs_cmd_t;

endpackage

>>> design/mrqs_ram.sv
module mrqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> design/mrqs_ctrl.sv
module mrqs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output mrqs_pkg::mrqs_cmd_t cmd
);
    import mrqs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.execute = (state_reg == S_EXEC);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_EXEC;
            S_EXEC: state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_exec_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.execute) else $error("execute missing");
    a_out_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> out_valid) else $error("result missing");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("accept while busy");
endmodule

>>> design/mrqs_datapath.sv
module mrqs_datapath #(
    parameter int NUM_QUEUES   = mrqs_pkg::NUM_QUEUES_DEF,
    parameter int POOL_SIZE    = mrqs_pkg::POOL_SIZE_DEF,
    parameter int PAYLOAD_BITS = mrqs_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mrqs_pkg::mrqs_cmd_t cmd,
    input  mrqs_pkg::in_item_t  in_item,
    output mrqs_pkg::out_item_t out_item
);
    import mrqs_pkg::*;

    localparam int QW = $clog2(NUM_QUEUES);
    localparam int PW = $clog2(POOL_SIZE);
    localparam int CW = PW + 1;
    localparam int RW = QW + 1;

    in_item_t          req_reg;
    logic [QW-1:0]     q;
    // pool link: valid bit means written; otherwise reads as index+1
    logic [POOL_SIZE-1:0] link_vld_reg;
    logic [PW-1:0]     free_head_reg;
    logic [CW-1:0]     free_count_reg;
    logic [PW-1:0]     mb_head_reg [NUM_QUEUES];
    logic [PW-1:0]     mb_tail_reg [NUM_QUEUES];
    logic [CW-1:0]     mb_count_reg [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] sched_reg;
    logic [NUM_QUEUES-1:0] listed_reg;
    logic [QW-1:0]     ready_link_reg [NUM_QUEUES];
    logic [QW-1:0]     ready_head_reg;
    logic [QW-1:0]     ready_tail_reg;
    logic [RW-1:0]     ready_count_reg;
    out_item_t         out_reg;

    // memory ports
    logic [PW-1:0]           raddr;
    logic [PW-1:0]           link_rd, link_raw;
    logic                    link_rd_vld_reg;
    logic [PW-1:0]           link_ra_reg;
    logic [PAYLOAD_BITS-1:0] pay_rd;
    logic                    link_we, pay_we;
    logic [PW-1:0]           link_wa, link_wd;

    assign q = in_item.queue_id[QW-1:0];

    // read address from fresh input in capture cycle
    always_comb
    begin
        case (in_item.req_type)
            REQ_PUSH: raddr = free_head_reg;
            default:  raddr = mb_head_reg[q];
        endcase
    end

    mrqs_ram #(.WIDTH(PW), .DEPTH(POOL_SIZE)) u_link (
        .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
        .raddr(raddr), .rdata(link_raw));

    mrqs_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(POOL_SIZE)) u_pay (
        .clk(clk), .we(pay_we), .waddr(free_head_reg),
        .wdata(req_reg.payload[PAYLOAD_BITS-1:0]),
        .raddr(raddr), .rdata(pay_rd));

    always_ff @(posedge clk)
    begin
        link_ra_reg     <= raddr;
        link_rd_vld_reg <= link_vld_reg[raddr];
    end

    assign link_rd = link_rd_vld_reg ? link_raw : PW'(link_ra_reg + 1'b1);

    logic [QW-1:0]  rq;
    logic           is_push, is_take, is_done, is_ready;
    logic           push_ok, take_ok, ready_ok, done_ok, relist;
    logic [PW-1:0]  node;

    assign rq       = req_reg.queue_id[QW-1:0];
    assign is_push  = cmd.execute && req_reg.req_type == REQ_PUSH;
    assign is_ready = cmd.execute && req_reg.req_type == REQ_TAKE_READY;
    assign is_take  = cmd.execute && req_reg.req_type == REQ_TAKE_MSG;
    assign is_done  = cmd.execute && req_reg.req_type == REQ_DONE;
    assign push_ok  = is_push && free_count_reg != '0;
    assign ready_ok = is_ready && ready_count_reg != '0;
    assign take_ok  = is_take && mb_count_reg[rq] != '0;
    assign done_ok  = is_done && sched_reg[rq] && !listed_reg[rq];
    assign relist   = (push_ok && !sched_reg[rq]) || (done_ok && mb_count_reg[rq] != '0);
    assign node     = push_ok ? free_head_reg : mb_head_reg[rq];

    assign pay_we = push_ok;

    // push links old tail to new node; take returns node to free list
    always_comb
    begin
        link_we = 1'b0;
        link_wa = mb_tail_reg[rq];
        link_wd = free_head_reg;
        if (push_ok && mb_count_reg[rq] != '0)
        begin
            link_we = 1'b1;
        end
        else if (take_ok)
        begin
            link_we = 1'b1;
            link_wa = node;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg    <= '0;
            free_head_reg   <= '0;
            free_count_reg  <= CW'(POOL_SIZE);
            sched_reg       <= '0;
            listed_reg      <= '0;
            ready_head_reg  <= '0;
            ready_tail_reg  <= '0;
            ready_count_reg <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                mb_count_reg[i] <= '0;
            end
        end
        else
        begin
            if (link_we)
            begin
                link_vld_reg[link_wa] <= 1'b1;
            end
            if (push_ok)
            begin
                free_head_reg  <= link_rd;
                free_count_reg <= free_count_reg - 1'b1;
                mb_count_reg[rq] <= mb_count_reg[rq] + 1'b1;
                sched_reg[rq] <= 1'b1;
            end
            if (take_ok)
            begin
                free_head_reg  <= node;
                free_count_reg <= free_count_reg + 1'b1;
                mb_count_reg[rq] <= mb_count_reg[rq] - 1'b1;
            end
            if (done_ok && mb_count_reg[rq] == '0)
            begin
                sched_reg[rq] <= 1'b0;
            end
            if (ready_ok)
            begin
                listed_reg[ready_head_reg] <= 1'b0;
                ready_count_reg <= ready_count_reg - 1'b1;
                if (ready_count_reg != RW'(1))
                begin
                    ready_head_reg <= ready_link_reg[ready_head_reg];
                end
            end
            if (relist)
            begin
                listed_reg[rq]  <= 1'b1;
                ready_tail_reg  <= rq;
                ready_count_reg <= ready_count_reg + 1'b1;
                if (ready_count_reg == '0)
                begin
                    ready_head_reg <= rq;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= in_item;
        end
        if (push_ok)
        begin
            mb_tail_reg[rq] <= free_head_reg;
            if (mb_count_reg[rq] == '0)
            begin
                mb_head_reg[rq] <= free_head_reg;
            end
        end
        if (take_ok && mb_count_reg[rq] != CW'(1))
        begin
            mb_head_reg[rq] <= link_rd;
        end
        if (relist && ready_count_reg != '0)
        begin
            ready_link_reg[ready_tail_reg] <= rq;
        end
        if (cmd.execute)
        begin
            out_reg.status      <= ST_OK;
            out_reg.queue_out   <= req_reg.queue_id;
            out_reg.payload_out <= '0;
            if (is_push && !push_ok)
            begin
                out_reg.status <= ST_FULL;
            end
            if ((is_ready && !ready_ok) || (is_take && !take_ok))
            begin
                out_reg.status <= ST_EMPTY;
            end
            if (is_done && !done_ok)
            begin
                out_reg.status <= ST_REFUSED;
            end
            if (ready_ok)
            begin
                out_reg.queue_out <= 4'(ready_head_reg);
            end
            if (take_ok)
            begin
                out_reg.payload_out <= 32'(pay_rd);
            end
        end
    end

    assign out_item = out_reg;

    a_ready_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ready_count_reg <= RW'(NUM_QUEUES)) else $error("ready overflow");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= CW'(POOL_SIZE)) else $error("free overflow");
    a_listed_sched: assert property (@(posedge clk) disable iff (!rst_n)
        (listed_reg & ~sched_reg) == '0) else $error("listed but unscheduled");
endmodule

>>> design/mailbox_ready_queue_scheduler_top.sv
// Mailbox ready-queue scheduler. Sixteen message mailboxes share one linked
// pool of 256 handles; queues with waiting work are listed once each in a
// ready FIFO. One request is served at a time: it is taken when in_ready is
// high, its pool memories are read at that accepting edge, the read data is
// used and the update written at the end of the next cycle, and its single
// result is then held on the out channel until taken.
// An item passes through the registered read of the pool memories and then
// the update, and its result may wait on an output stall. No clearing pass is
// needed after reset: per-entry link valid bits give the initial free-list
// chain.
module mailbox_ready_queue_scheduler_top #(
    parameter int NUM_QUEUES   = mrqs_pkg::NUM_QUEUES_DEF,
    parameter int POOL_SIZE    = mrqs_pkg::POOL_SIZE_DEF,
    parameter int PAYLOAD_BITS = mrqs_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mrqs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mrqs_pkg::out_item_t out_data
);
    import mrqs_pkg::*;

    mrqs_cmd_t cmd;

    // sequence each item: capture, execute, present
    mrqs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd));

    // hold mailbox, free list and ready list state
    mrqs_datapath #(
        .NUM_QUEUES(NUM_QUEUES), .POOL_SIZE(POOL_SIZE), .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_data), .out_item(out_data));
endmodule

>>> tb/sv/mailbox_ready_queue_scheduler_top_tb.sv
`timescale 1ns / 100ps

module mailbox_ready_queue_scheduler_top_tb;
    import mrqs_pkg::*;

    localparam int NQ = 16;
    localparam int NP = 256;
    localparam int RANDOM_ITEMS = 700;
    localparam int FILL_ITEMS = 280;
    localparam int DIR_ROWS = 22;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    mailbox_ready_queue_scheduler_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    // Scheduler shadow state, kept in step with every accepted request.
    logic [31:0] sh_payload [NP];
    logic [7:0]  sh_link [NP];
    logic [7:0]  sh_free_head;
    int          sh_free_count;
    logic [7:0]  sh_mb_head [NQ];
    logic [7:0]  sh_mb_tail [NQ];
    int          sh_mb_count [NQ];
    bit          sh_sched [NQ];
    bit          sh_listed [NQ];
    logic [3:0]  sh_ready_link [NQ];
    logic [3:0]  sh_ready_head;
    logic [3:0]  sh_ready_tail;
    int          sh_ready_count;

    out_item_t   pending_results [$];
    int          errors;
    int          results_seen;
    int          full_seen;
    int          refused_seen;
    bit          long_hold;
    bit          stim_done;

    always #2 clk = ~clk;

    initial
    begin
        #4000000;
        $display("mailbox_ready_queue_scheduler_top verification failed");
        $finish;
    end

    task automatic shadow_reset();
        for (int i = 0; i < NP; i++)
        begin
            sh_link[i] = 8'(i + 1);
            sh_payload[i] = '0;
        end
        sh_free_head = '0;
        sh_free_count = NP;
        for (int q = 0; q < NQ; q++)
        begin
            sh_mb_count[q] = 0;
            sh_sched[q] = 0;
            sh_listed[q] = 0;
            sh_mb_head[q] = '0;
            sh_mb_tail[q] = '0;
            sh_ready_link[q] = '0;
        end
        sh_ready_head = '0;
        sh_ready_tail = '0;
        sh_ready_count = 0;
    endtask

    function automatic void ready_append(logic [3:0] q);
        if (sh_ready_count == 0)
            sh_ready_head = q;
        else
            sh_ready_link[sh_ready_tail] = q;
        sh_ready_tail = q;
        sh_ready_count++;
        sh_listed[q] = 1;
    endfunction

    // Apply one request to the shadow state and return its result.
    function automatic out_item_t schedule_step(in_item_t it);
        out_item_t r;
        logic [7:0] node;
        logic [3:0] q;
        q = it.queue_id;
        r.status = ST_OK;
        r.queue_out = it.queue_id;
        r.payload_out = '0;
        case (it.req_type)
            REQ_PUSH:
            begin
                if (sh_free_count == 0)
                    r.status = ST_FULL;
                else
                begin
                    node = sh_free_head;
                    sh_free_head = sh_link[node];
                    sh_free_count--;
                    sh_payload[node] = it.payload;
                    if (sh_mb_count[q] == 0)
                        sh_mb_head[q] = node;
                    else
                        sh_link[sh_mb_tail[q]] = node;
                    sh_mb_tail[q] = node;
                    sh_mb_count[q]++;
                    if (!sh_sched[q])
                    begin
                        ready_append(q);
                        sh_sched[q] = 1;
                    end
                end
            end
            REQ_TAKE_READY:
            begin
                if (sh_ready_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.queue_out = sh_ready_head;
                    sh_listed[sh_ready_head] = 0;
                    sh_ready_count--;
                    if (sh_ready_count != 0)
                        sh_ready_head = sh_ready_link[sh_ready_head];
                end
            end
            REQ_TAKE_MSG:
            begin
                if (sh_mb_count[q] == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    node = sh_mb_head[q];
                    r.payload_out = sh_payload[node];
                    sh_mb_count[q]--;
                    if (sh_mb_count[q] != 0)
                        sh_mb_head[q] = sh_link[node];
                    sh_link[node] = sh_free_head;
                    sh_free_head = node;
                    sh_free_count++;
                end
            end
            default:
            begin
                if (!sh_sched[q] || sh_listed[q])
                    r.status = ST_REFUSED;
                else if (sh_mb_count[q] != 0)
                    ready_append(q);
                else
                    sh_sched[q] = 0;
            end
        endcase
        return r;
    endfunction

    // Directed table: request plus, where obvious, the typed-in answer.
    typedef struct packed {
        in_item_t  req;
        bit        fixed;
        out_item_t answer;
    } dir_row_t;

    dir_row_t dir_rows [DIR_ROWS];

    function automatic dir_row_t mk(logic [1:0] rt, logic [3:0] q, logic [31:0] p,
                                    bit fx, logic [1:0] st, logic [3:0] qo,
                                    logic [31:0] po);
        dir_row_t d;
        d.req = '{req_type: rt, queue_id: q, payload: p};
        d.fixed = fx;
        d.answer = '{status: st, queue_out: qo, payload_out: po};
        return d;
    endfunction

    initial
    begin
        // empty scheduler after reset
        dir_rows[0]  = mk(REQ_TAKE_READY, 4'd7, 32'h0, 1, ST_EMPTY, 4'd7, 32'h0);
        dir_rows[1]  = mk(REQ_TAKE_MSG, 4'd15, 32'h0, 1, ST_EMPTY, 4'd15, 32'h0);
        dir_rows[2]  = mk(REQ_DONE, 4'd0, 32'h0, 1, ST_REFUSED, 4'd0, 32'h0);
        // extreme payloads and ids
        dir_rows[3]  = mk(REQ_PUSH, 4'd15, 32'hFFFF_FFFF, 1, ST_OK, 4'd15, 32'h0);
        dir_rows[4]  = mk(REQ_PUSH, 4'd0, 32'h0, 1, ST_OK, 4'd0, 32'h0);
        dir_rows[5]  = mk(REQ_PUSH, 4'd15, 32'hA5A5_5A5A, 0, 0, 0, 0);
        // done while still listed is refused
        dir_rows[6]  = mk(REQ_DONE, 4'd15, 32'h0, 1, ST_REFUSED, 4'd15, 32'h0);
        dir_rows[7]  = mk(REQ_TAKE_READY, 4'd3, 32'h0, 1, ST_OK, 4'd15, 32'h0);
        dir_rows[8]  = mk(REQ_TAKE_MSG, 4'd15, 32'h0, 1, ST_OK, 4'd15, 32'hFFFF_FFFF);
        // done on non-empty queue relists it
        dir_rows[9]  = mk(REQ_DONE, 4'd15, 32'h0, 1, ST_OK, 4'd15, 32'h0);
        dir_rows[10] = mk(REQ_TAKE_READY, 4'd0, 32'h0, 1, ST_OK, 4'd0, 32'h0);
        dir_rows[11] = mk(REQ_TAKE_READY, 4'd0, 32'h0, 1, ST_OK, 4'd15, 32'h0);
        dir_rows[12] = mk(REQ_TAKE_MSG, 4'd15, 32'h0, 1, ST_OK, 4'd15, 32'hA5A5_5A5A);
        dir_rows[13] = mk(REQ_TAKE_MSG, 4'd15, 32'h0, 1, ST_EMPTY, 4'd15, 32'h0);
        // done on empty scheduled queue clears the mark
        dir_rows[14] = mk(REQ_DONE, 4'd15, 32'h0, 1, ST_OK, 4'd15, 32'h0);
        dir_rows[15] = mk(REQ_DONE, 4'd15, 32'h0, 1, ST_REFUSED, 4'd15, 32'h0);
        dir_rows[16] = mk(REQ_TAKE_MSG, 4'd0, 32'h0, 1, ST_OK, 4'd0, 32'h0);
        dir_rows[17] = mk(REQ_DONE, 4'd0, 32'h0, 1, ST_OK, 4'd0, 32'h0);
        dir_rows[18] = mk(REQ_PUSH, 4'd9, 32'h8000_0001, 0, 0, 0, 0);
        dir_rows[19] = mk(REQ_PUSH, 4'd4, 32'h7FFF_FFFE, 0, 0, 0, 0);
        dir_rows[20] = mk(REQ_TAKE_READY, 4'd2, 32'h0, 0, 0, 0, 0);
        dir_rows[21] = mk(REQ_TAKE_READY, 4'd2, 32'h0, 0, 0, 0, 0);
    end

    out_item_t dir_answers [$];
    bit        dir_fixed [$];

    // Offer one item and hold it until taken; track the result it causes.
    task automatic send_item(in_item_t it, bit fx, out_item_t ans);
        out_item_t r;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = schedule_step(it);
        if (fx && r != ans)
        begin
            $display("%0t directed table disagrees: table %h shadow %h", $time, ans, r);
            errors++;
        end
        pending_results.push_back(r);
        if (it.req_type == REQ_PUSH && r.status == ST_FULL)
            full_seen++;
        if (r.status == ST_REFUSED)
            refused_seen++;
    endtask

    task automatic idle_cycles(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic in_item_t rand_item(int mode);
        in_item_t it;
        int pick;
        it.queue_id = 4'($urandom_range(0, NQ - 1));
        it.payload = $urandom;
        pick = $urandom_range(0, 99);
        if (mode == 1)
            it.req_type = (pick < 97) ? REQ_PUSH : REQ_TAKE_READY;
        else if (mode == 2)
            it.req_type = (pick < 70) ? REQ_TAKE_MSG : REQ_DONE;
        else
        begin
            // worker-like traffic: pushes, takes and dones mixed
            if (pick < 35)
                it.req_type = REQ_PUSH;
            else if (pick < 55)
                it.req_type = REQ_TAKE_READY;
            else if (pick < 80)
                it.req_type = REQ_TAKE_MSG;
            else
                it.req_type = REQ_DONE;
            // steer most non-push requests at queues 0 to 3
            if (it.req_type != REQ_PUSH && pick % 3 != 0 && sh_ready_count >= 0)
                it.queue_id = 4'($urandom_range(0, 3));
        end
        if (pick % 7 == 0)
            it.payload = (pick % 2) ? 32'hFFFF_FFFF : 32'h0;
        return it;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Sender.
    initial
    begin
        in_item_t it;
        int burst;
        int mode;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        errors = 0;
        results_seen = 0;
        full_seen = 0;
        refused_seen = 0;
        long_hold = 1'b0;
        stim_done = 1'b0;
        shadow_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].answer);
        // hold off until every directed result has come
        wait_drained();

        // Fill the pool past full, with the receiver holding off at first.
        long_hold = 1'b1;
        for (int i = 0; i < FILL_ITEMS; i++)
            send_item(rand_item(1), 0, '0);
        long_hold = 1'b0;
        // drain it again
        for (int i = 0; i < FILL_ITEMS; i++)
            send_item(rand_item(2), 0, '0);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; )
        begin
            burst = $urandom_range(1, 24);
            mode = ($urandom_range(0, 9) == 0) ? 1 + $urandom_range(0, 1) : 0;
            for (int k = 0; k < burst; k++)
            begin
                send_item(rand_item(mode), 0, '0);
                n++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random stall pattern, with a long hold while the pool fills.
    initial
    begin
        int hold_cycles;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                for (hold_cycles = 0; hold_cycles < 400; hold_cycles++)
                    @(posedge clk);
                out_ready <= 1'b1;
                while (long_hold)
                    @(posedge clk);
            end
            else if ($urandom_range(0, 15) < 4)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, out_data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                begin
                    $display("%0t status expected %0d actual %0d",
                             $time, want.status, out_data.status);
                    errors++;
                end
                if (out_data.queue_out !== want.queue_out)
                begin
                    $display("%0t queue_out expected %0d actual %0d",
                             $time, want.queue_out, out_data.queue_out);
                    errors++;
                end
                if (out_data.payload_out !== want.payload_out)
                begin
                    $display("%0t payload_out expected %h actual %h",
                             $time, want.payload_out, out_data.payload_out);
                    errors++;
                end
            end
        end
    end

    // End of run: drain, let the pipeline settle, report.
    initial
    begin
        wait (stim_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
            errors++;
        $display("Ran %0d results: pool filled %0d times past full, %0d refused dones.",
                 results_seen, full_seen, refused_seen);
        if (errors == 0)
            $display("mailbox_ready_queue_scheduler_top verification clean");
        else
            $display("mailbox_ready_queue_scheduler_top verification failed");
        $finish;
    end

endmodule

>>> files.f
design/mrqs_pkg.sv
design/mrqs_ram.sv
design/mrqs_ctrl.sv
design/mrqs_datapath.sv
design/mailbox_ready_queue_scheduler_top.sv
tb/sv/mailbox_ready_queue_scheduler_top_tb.sv
